>>> hw/rtl/sha1_pkg.sv
// Shared types, constants and helper functions for the SHA-1 stream hasher.
package sha1_pkg;

    typedef logic [31:0] sha1_word_t;
    typedef logic [4:0][31:0] sha1_hash_t;

    // Block store geometry
    localparam int BLK_WORDS = 16;
    localparam int BLK_AW = $clog2(BLK_WORDS);
    localparam int ROUNDS = 80;
    localparam int ROUND_W = $clog2(ROUNDS);
    localparam int HASH_WORDS = 5;
    localparam int OIDX_W = 3;

    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);
    localparam logic [ROUND_W-1:0] SCHED_START = ROUND_W'(BLK_WORDS);
    localparam logic [OIDX_W-1:0] LAST_OIDX = OIDX_W'(HASH_WORDS - 1);
    localparam logic [BLK_AW-1:0] LAST_WORD = BLK_AW'(BLK_WORDS - 1);
    localparam logic [BLK_AW-1:0] LEN_HI_WORD = BLK_AW'(14);
    localparam logic [BLK_AW-1:0] LEN_LO_WORD = BLK_AW'(15);
    localparam logic [5:0] LAST_BYTE_POS = 6'd63;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Initial hash value, H0 at index 0
    localparam sha1_hash_t SHA1_IV = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam sha1_word_t K0 = 32'h5A827999;
    localparam sha1_word_t K1 = 32'h6ED9EBA1;
    localparam sha1_word_t K2 = 32'h8F1BBCDC;
    localparam sha1_word_t K3 = 32'hCA62C1D6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD_HEAD,
        ST_PAD_FILL,
        ST_OUT
    } sha1_state_t;

    // Block store access for one cycle
    typedef struct packed {
        logic              we;
        logic [BLK_AW-1:0] waddr;
        sha1_word_t        wdata;
        logic [BLK_AW-1:0] raddr;
    } sha1_mem_req_t;

    // Compression core controls
    typedef struct packed {
        logic               init_work;
        logic               round_en;
        logic [ROUND_W-1:0] round;
        logic               update;
        logic               reinit;
    } sha1_core_ctl_t;

    function automatic sha1_word_t rotl1(input sha1_word_t v);
        rotl1 = {v[30:0], v[31]};
    endfunction

    function automatic sha1_word_t rotl5(input sha1_word_t v);
        rotl5 = {v[26:0], v[31:27]};
    endfunction

    function automatic sha1_word_t rotl30(input sha1_word_t v);
        rotl30 = {v[1:0], v[31:2]};
    endfunction

endpackage

>>> hw/rtl/sha1_stream_if.sv
// Request channel interfaces: message bytes in, digest words out.
interface sha1_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_item;

    modport source (output valid, data_byte, byte_valid, last_item, input ready);
    modport sink (input valid, data_byte, byte_valid, last_item, output ready);
endinterface

interface sha1_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;

    modport source (output valid, digest_word, word_index, digest_last, input ready);
    modport sink (input valid, digest_word, word_index, digest_last, output ready);
endinterface

>>> hw/rtl/sha1_blkmem.sv
// Sixteen-word block store, one write and one registered read per cycle.
module sha1_blkmem import sha1_pkg::*;
(
    input  logic          clk,
    input  sha1_mem_req_t req,
    output sha1_word_t    rdata
);

    sha1_word_t mem [BLK_WORDS];
    sha1_word_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/sha1_core.sv
// SHA-1 compression: message schedule window, one round per cycle, hash words.
module sha1_core import sha1_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  sha1_core_ctl_t ctl,
    input  sha1_word_t     rdata,
    output sha1_hash_t     hash
);

    sha1_hash_t hash_reg;
    sha1_word_t a_reg, b_reg, c_reg, d_reg, e_reg;
    sha1_word_t sched_reg [BLK_WORDS];

    sha1_word_t w_cur;
    sha1_word_t f_val;
    sha1_word_t k_val;
    sha1_word_t t_val;

    // schedule word: block word for the first 16 rounds, expansion after
    always_comb
    begin
        if (ctl.round < SCHED_START)
        begin
            w_cur = rdata;
        end
        else
        begin
            w_cur = rotl1(sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0]);
        end
    end

    // round function and constant
    always_comb
    begin
        if (ctl.round < ROUND_W'(20))
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K0;
        end
        else if (ctl.round < ROUND_W'(40))
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end
        else if (ctl.round < ROUND_W'(60))
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
        t_val = rotl5(a_reg) + f_val + e_reg + w_cur + k_val;
    end

    // working variables and schedule window
    always_ff @(posedge clk)
    begin
        if (ctl.init_work)
        begin
            a_reg <= hash_reg[0];
            b_reg <= hash_reg[1];
            c_reg <= hash_reg[2];
            d_reg <= hash_reg[3];
            e_reg <= hash_reg[4];
        end
        else if (ctl.round_en)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= rotl30(b_reg);
            d_reg <= c_reg;
            e_reg <= d_reg;
            for (int i = 0; i < BLK_WORDS - 1; i++)
            begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[BLK_WORDS-1] <= w_cur;
        end
    end

    // chaining value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= SHA1_IV;
        end
        else if (ctl.reinit)
        begin
            hash_reg <= SHA1_IV;
        end
        else if (ctl.update)
        begin
            hash_reg[0] <= hash_reg[0] + a_reg;
            hash_reg[1] <= hash_reg[1] + b_reg;
            hash_reg[2] <= hash_reg[2] + c_reg;
            hash_reg[3] <= hash_reg[3] + d_reg;
            hash_reg[4] <= hash_reg[4] + e_reg;
        end
    end

    assign hash = hash_reg;

endmodule

>>> hw/rtl/sha1_stream_hasher.sv
// Streaming SHA-1 hasher top level: byte packing, padding, control and digest output.
//
// msg channel: one request per message byte. byte_valid marks whether data_byte
// belongs to the message; last_item closes the message and starts padding.
// A request with byte_valid low and last_item high closes the message with the
// bytes taken so far (an empty message if none).
// digest channel: five requests per message, H0 first, word_index 0..4,
// digest_last on the fifth.
// Bytes are taken one per cycle while a block fills. The 64th byte of a block
// starts a compression (one read setup, 80 rounds on the single round unit,
// one chaining add), during which msg.ready is low, so no byte is taken until
// the block is done. Closing writes the pad word, then the zero/length fill (a
// full extra block when the length does not fit the last one), runs one or
// two compressions, and outputs the five digest words in order.
// The digest leaves through an output register; a stall on digest.ready holds
// the word and pauses the output sequence, while a byte request can already be
// taken once the last word sits in the register.
// Reset (rst_n, asynchronous) loads the SHA-1 initial value and clears the
// bit count; the block store needs no clearing, every word is written first.
module sha1_stream_hasher import sha1_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    sha1_msg_if.sink             msg,
    sha1_digest_if.source        digest
);

    sha1_state_t state_reg, state_next;

    logic [63:0]             bit_len_reg, bit_len_next;
    logic [23:0]             acc_reg, acc_next;
    logic [ROUND_W-1:0]      round_reg, round_next;
    logic [BLK_AW-1:0]       pw_reg, pw_next;
    logic                    close_reg, close_next;
    logic                    head_done_reg, head_done_next;
    logic                    len_blk_reg, len_blk_next;
    logic [OIDX_W-1:0]       oidx_reg, oidx_next;
    logic                    dv_reg, dv_next;
    sha1_word_t              dword_reg, dword_next;
    logic [OIDX_W-1:0]       dindex_reg, dindex_next;
    logic                    dlast_reg, dlast_next;

    sha1_mem_req_t  mem_req;
    sha1_core_ctl_t core_ctl;
    sha1_word_t     rdata;
    sha1_hash_t     hash;

    logic              msg_acc;
    logic              out_free;
    logic              out_load;
    logic [5:0]        pos;
    logic [BLK_AW-1:0] head_wi;
    sha1_word_t        pad_word;
    sha1_word_t        fill_word;

    sha1_blkmem u_blkmem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    sha1_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (core_ctl),
        .rdata (rdata),
        .hash  (hash)
    );

    assign msg.ready = (state_reg == ST_IDLE);
    assign msg_acc   = msg.valid && msg.ready;
    assign out_free  = !dv_reg || digest.ready;
    assign pos       = bit_len_reg[8:3];
    assign head_wi   = bit_len_reg[8:5];

    // first pad word: pending bytes of the partial word, then 0x80
    always_comb
    begin
        case (pos[1:0])
            2'd0:    pad_word = {PAD_BYTE, 24'h0};
            2'd1:    pad_word = {acc_reg[7:0], PAD_BYTE, 16'h0};
            2'd2:    pad_word = {acc_reg[15:0], PAD_BYTE, 8'h0};
            2'd3:    pad_word = {acc_reg[23:0], PAD_BYTE};
            default: pad_word = {PAD_BYTE, 24'h0};
        endcase
    end

    // zero fill, with the bit length in the last two words of the final block
    always_comb
    begin
        if (len_blk_reg && pw_reg == LEN_HI_WORD)
        begin
            fill_word = bit_len_reg[63:32];
        end
        else if (len_blk_reg && pw_reg == LEN_LO_WORD)
        begin
            fill_word = bit_len_reg[31:0];
        end
        else
        begin
            fill_word = '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (msg_acc)
                begin
                    if (msg.byte_valid && pos == LAST_BYTE_POS)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (msg.last_item)
                    begin
                        state_next = ST_PAD_HEAD;
                    end
                end
            end
            ST_LOAD:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!close_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!head_done_reg)
                begin
                    state_next = ST_PAD_HEAD;
                end
                else if (len_blk_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_PAD_FILL;
                end
            end
            ST_PAD_HEAD:
            begin
                state_next = (head_wi == LAST_WORD) ? ST_LOAD : ST_PAD_FILL;
            end
            ST_PAD_FILL:
            begin
                if (pw_reg == LAST_WORD)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_OUT:
            begin
                if (out_free && oidx_reg == LAST_OIDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // block store and core controls
    always_comb
    begin
        mem_req.we    = 1'b0;
        mem_req.waddr = pos[5:2];
        mem_req.wdata = {acc_reg, msg.data_byte};
        mem_req.raddr = '0;
        core_ctl.init_work = 1'b0;
        core_ctl.round_en  = 1'b0;
        core_ctl.round     = round_reg;
        core_ctl.update    = 1'b0;
        core_ctl.reinit    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                mem_req.we = msg_acc && msg.byte_valid && (pos[1:0] == 2'd3);
            end
            ST_LOAD:
            begin
                core_ctl.init_work = 1'b1;
            end
            ST_ROUND:
            begin
                mem_req.raddr     = round_reg[BLK_AW-1:0] + BLK_AW'(1);
                core_ctl.round_en = 1'b1;
            end
            ST_UPDATE:
            begin
                core_ctl.update = 1'b1;
            end
            ST_PAD_HEAD:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = head_wi;
                mem_req.wdata = pad_word;
            end
            ST_PAD_FILL:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pw_reg;
                mem_req.wdata = fill_word;
            end
            ST_OUT:
            begin
                out_load        = out_free;
                core_ctl.reinit = out_free && (oidx_reg == LAST_OIDX);
            end
            default:
            begin
                mem_req.we = 1'b0;
            end
        endcase
    end

    // counters, flags and the output register
    always_comb
    begin
        bit_len_next   = bit_len_reg;
        acc_next       = acc_reg;
        round_next     = round_reg;
        pw_next        = pw_reg;
        close_next     = close_reg;
        head_done_next = head_done_reg;
        len_blk_next   = len_blk_reg;
        oidx_next      = oidx_reg;
        dword_next     = dword_reg;
        dindex_next    = dindex_reg;
        dlast_next     = dlast_reg;
        dv_next        = dv_reg && !digest.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (msg_acc)
                begin
                    if (msg.byte_valid)
                    begin
                        bit_len_next = bit_len_reg + 64'd8;
                        acc_next     = {acc_reg[15:0], msg.data_byte};
                    end
                    close_next     = msg.last_item;
                    head_done_next = 1'b0;
                end
            end
            ST_LOAD:
            begin
                round_next = '0;
            end
            ST_ROUND:
            begin
                round_next = round_reg + ROUND_W'(1);
            end
            ST_UPDATE:
            begin
                if (close_reg && head_done_reg && !len_blk_reg)
                begin
                    pw_next      = '0;
                    len_blk_next = 1'b1;
                end
            end
            ST_PAD_HEAD:
            begin
                head_done_next = 1'b1;
                len_blk_next   = (head_wi < LEN_HI_WORD);
                pw_next        = head_wi + BLK_AW'(1);
            end
            ST_PAD_FILL:
            begin
                pw_next = pw_reg + BLK_AW'(1);
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    if (oidx_reg == LAST_OIDX)
                    begin
                        oidx_next    = '0;
                        bit_len_next = '0;
                        close_next   = 1'b0;
                    end
                    else
                    begin
                        oidx_next = oidx_reg + OIDX_W'(1);
                    end
                end
            end
            default:
            begin
                round_next = round_reg;
            end
        endcase

        if (out_load)
        begin
            dv_next     = 1'b1;
            dword_next  = hash[oidx_reg];
            dindex_next = oidx_reg;
            dlast_next  = (oidx_reg == LAST_OIDX);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_len_reg   <= '0;
            round_reg     <= '0;
            pw_reg        <= '0;
            close_reg     <= 1'b0;
            head_done_reg <= 1'b0;
            len_blk_reg   <= 1'b0;
            oidx_reg      <= '0;
            dv_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_len_reg   <= bit_len_next;
            round_reg     <= round_next;
            pw_reg        <= pw_next;
            close_reg     <= close_next;
            head_done_reg <= head_done_next;
            len_blk_reg   <= len_blk_next;
            oidx_reg      <= oidx_next;
            dv_reg        <= dv_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        dword_reg  <= dword_next;
        dindex_reg <= dindex_next;
        dlast_reg  <= dlast_next;
    end

    assign digest.valid       = dv_reg;
    assign digest.digest_word = dword_reg;
    assign digest.word_index  = dindex_reg;
    assign digest.digest_last = dlast_reg;

endmodule

>>> verif/tb.sv
// Testbench for the SHA-1 stream hasher: byte requests in, digest words checked in order.
module tb import sha1_pkg::*;;

    localparam int ITEM_TARGET = 370;
    localparam int MAX_WAIT = 17;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 300;
    localparam int REPORT_MAX = 10;
    localparam logic [5:0] LEN_POS = 6'd56;

    // One digest word as it leaves the block
    typedef struct packed {
        sha1_word_t        dword;
        logic [OIDX_W-1:0] idx;
        logic              is_last;
    } digest_beat_t;

    logic clk;
    logic rst_n;

    sha1_msg_if msg ();
    sha1_digest_if digest ();

    sha1_stream_hasher i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg),
        .digest (digest)
    );

    // Hasher model state
    sha1_hash_t   hash_model = SHA1_IV;
    sha1_word_t   block_model [BLK_WORDS];
    logic [63:0]  bits_taken = '0;
    digest_beat_t digest_q [$];

    int  err_count = 0;
    int  items_sent = 0;
    bit  no_idle = 1'b0;

    // 2-unit clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic sha1_word_t rotate_left(input sha1_word_t v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // 80-round compression of the model block into the model hash
    function automatic void compress_model();
        sha1_word_t w [ROUNDS];
        sha1_word_t a, b, c, d, e, f, k, t;
        int r;
        for (r = 0; r < BLK_WORDS; r++)
            w[r] = block_model[r];
        for (r = BLK_WORDS; r < ROUNDS; r++)
            w[r] = rotate_left(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        a = hash_model[0];
        b = hash_model[1];
        c = hash_model[2];
        d = hash_model[3];
        e = hash_model[4];
        for (r = 0; r < ROUNDS; r++)
        begin
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = K0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = K1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K3;
            end
            t = rotate_left(a, 5) + f + e + w[r] + k;
            e = d;
            d = c;
            c = rotate_left(b, 30);
            b = a;
            a = t;
        end
        hash_model[0] = hash_model[0] + a;
        hash_model[1] = hash_model[1] + b;
        hash_model[2] = hash_model[2] + c;
        hash_model[3] = hash_model[3] + d;
        hash_model[4] = hash_model[4] + e;
    endfunction

    // Big-endian byte placement; the 64th byte of a block compresses it
    function automatic void put_model_byte(input logic [5:0] pos, input logic [7:0] b);
        int wi;
        int sh;
        wi = int'(pos[5:2]);
        sh = (3 - int'(pos[1:0])) * 8;
        block_model[wi][sh +: 8] = b;
        if (pos == LAST_BYTE_POS)
            compress_model();
    endfunction

    // Absorb one accepted request; a close queues the five digest words
    function automatic void predict_digest(input logic [7:0] b, input logic bv,
                                           input logic last);
        logic [63:0]  len;
        logic [5:0]   pos;
        digest_beat_t beat;
        int           i;
        if (bv)
        begin
            put_model_byte(bits_taken[8:3], b);
            bits_taken = bits_taken + 64'd8;
        end
        if (last)
        begin
            len = bits_taken;
            pos = len[8:3];
            put_model_byte(pos, PAD_BYTE);
            pos = pos + 6'd1;
            while (pos != LEN_POS)
            begin
                put_model_byte(pos, 8'h00);
                pos = pos + 6'd1;
            end
            for (i = 0; i < 8; i++)
                put_model_byte(LEN_POS + 6'(i), len[(7 - i) * 8 +: 8]);
            for (i = 0; i < HASH_WORDS; i++)
            begin
                beat.dword = hash_model[i];
                beat.idx = OIDX_W'(i);
                beat.is_last = (i == HASH_WORDS - 1);
                digest_q.push_back(beat);
            end
            hash_model = SHA1_IV;
            bits_taken = '0;
        end
    endfunction

    function automatic void flag_error(input string what);
        err_count++;
        if (err_count <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // Wait drawn per request; quiet stretches force back-to-back traffic
    function automatic int draw_wait();
        if (no_idle)
            return 0;
        if ($urandom_range(0, 1))
            return $urandom_range(0, MAX_WAIT);
        return $urandom_range(0, 2);
    endfunction

    // Send one msg request and update the model once it is taken
    task automatic send_req(input logic [7:0] b, input logic bv, input logic last);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            msg.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg.valid <= 1'b1;
        msg.data_byte <= b;
        msg.byte_valid <= bv;
        msg.last_item <= last;
        @(posedge clk);
        while (msg.ready !== 1'b1)
            @(posedge clk);
        predict_digest(b, bv, last);
        items_sent++;
    endtask

    // Random-content message of len bytes, with occasional idle requests
    task automatic send_message(input int len, input bit close_on_byte);
        int i;
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_req(8'($urandom), 1'b0, 1'b0);
            send_req(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
        end
        if (!close_on_byte || len == 0)
            send_req(8'($urandom), 1'b0, 1'b1);
    endtask

    // Empty message straight after reset, then again after reinit
    task automatic test_empty_message();
        send_req(8'hFF, 1'b0, 1'b1);
        send_req(8'($urandom), 1'b0, 1'b1);
    endtask

    // Short messages closed on their last byte, byte extremes
    task automatic test_short_messages();
        send_req(8'h61, 1'b1, 1'b0);
        send_req(8'h62, 1'b1, 1'b0);
        send_req(8'h63, 1'b1, 1'b1);
        send_req(8'h00, 1'b1, 1'b1);
        send_req(8'hFF, 1'b1, 1'b1);
    endtask

    // Idle requests and ignored bytes inside a message, closed with no byte
    task automatic test_idle_and_ignored();
        send_req(8'h3C, 1'b0, 1'b0);
        send_req(8'hA5, 1'b1, 1'b0);
        send_req(8'hFF, 1'b0, 1'b0);
        send_req(8'h5A, 1'b1, 1'b0);
        send_req(8'h00, 1'b0, 1'b0);
        send_req(8'hFF, 1'b0, 1'b1);
    endtask

    // Lengths around the one/two final block split and a full block
    task automatic test_pad_boundaries();
        no_idle = 1'b1;
        send_message(55, 1'b1);
        send_message(56, 1'b0);
        no_idle = 1'b0;
        send_message(63, 1'b0);
        send_message(64, 1'b1);
    endtask

    // Random messages, mostly short, some near block boundaries
    task automatic test_random_messages();
        int sel;
        int len;
        while (items_sent < ITEM_TARGET)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
                len = $urandom_range(0, 12);
            else if (sel < 9)
                len = $urandom_range(54, 65);
            else
                len = $urandom_range(13, 70);
            no_idle = ($urandom_range(0, 3) == 0);
            send_message(len, $urandom_range(0, 1));
        end
        no_idle = 1'b0;
    endtask

    // Digest sink: random stalls, in-order check against the model queue
    initial
    begin : digest_sink
        digest_beat_t got;
        digest_beat_t want;
        int           stall;
        digest.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                digest.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            digest.ready <= 1'b1;
            @(posedge clk);
            while (digest.valid !== 1'b1)
                @(posedge clk);
            got.dword = digest.digest_word;
            got.idx = digest.word_index;
            got.is_last = digest.digest_last;
            if (digest_q.size() == 0)
                flag_error($sformatf("unexpected digest word %h idx %0d", got.dword, got.idx));
            else
            begin
                want = digest_q.pop_front();
                if (got.dword !== want.dword)
                    flag_error($sformatf("digest_word exp %h got %h", want.dword, got.dword));
                if (got.idx !== want.idx)
                    flag_error($sformatf("word_index exp %0d got %0d", want.idx, got.idx));
                if (got.is_last !== want.is_last)
                    flag_error($sformatf("digest_last exp %b got %b",
                                         want.is_last, got.is_last));
            end
        end
    end

    // Cycle counter watchdog
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL sha1_stream_hasher");
        $finish;
    end

    // Test sequence
    initial
    begin : main_seq
        int i;
        for (i = 0; i < BLK_WORDS; i++)
            block_model[i] = '0;
        rst_n <= 1'b0;
        msg.valid <= 1'b0;
        msg.data_byte <= 8'h00;
        msg.byte_valid <= 1'b0;
        msg.last_item <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_message();
        test_short_messages();
        test_idle_and_ignored();
        test_pad_boundaries();
        test_random_messages();
        msg.valid <= 1'b0;

        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("PASS sha1_stream_hasher");
        else
            $display("FAIL sha1_stream_hasher");
        $finish;
    end

endmodule
